// ===== rtl/core/scli_pkg.sv =====
// shared types, character codes and message text of the stepper command line interpreter
// no dependencies; used by scli_ctrl, scli_datapath and the top level
package scli_pkg;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;

   // only the head of the line is ever matched: longest name plus its argument
   localparam int STORE_DEPTH = 6;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int IDX_W    = 5;
   localparam int GOOD_LEN = 22;
   localparam int BAD_LEN  = 17;
   localparam int DONE_LEN = 14;

   localparam logic [8*GOOD_LEN-1:0] GOOD_TEXT =
      {"- Command Accepted.", CH_LF, CH_LF, CH_CR};
   localparam logic [8*BAD_LEN-1:0] BAD_TEXT =
      {"- BAD Command.", CH_LF, CH_LF, CH_CR};
   localparam logic [8*DONE_LEN-1:0] DONE_TEXT =
      {CH_LF, CH_LF, "Finished!", CH_LF, CH_LF, CH_CR};

   typedef logic [STORE_DEPTH-1:0][7:0] line_head_type;

   typedef enum logic [3:0] {
      CMD_SNG, CMD_STS, CMD_STP, CMD_STMF, CMD_STMH,
      CMD_STDC, CMD_STDH, CMD_STD, CMD_ADC
   } cmd_type;

   localparam int NUM_CMDS = 9;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_ECHO, ST_ERASE_SP, ST_ERASE_BS,
      ST_LINE_FEED, ST_NAME, ST_REPLY, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      SEG_ECHO, SEG_SPACE, SEG_BACK, SEG_LF, SEG_NAME, SEG_REPLY, SEG_FINISH
   } seg_type;

   // what one received byte has to send, decided when it is taken
   typedef struct packed {
      logic echo;
      logic erase;
      logic finish;
      logic cmdline;
   } plan_type;

   typedef struct packed {
      plan_type plan;
      logic     hit;
      logic     good;
      cmd_type  cmd;
   } status_type;

   typedef struct packed {
      logic             load;
      logic             exec;
      seg_type          seg;
      logic [IDX_W-1:0] idx;
      logic             last;
   } ctrl_cmd_type;

   // match pattern, left aligned
   function automatic logic [39:0] cmd_pattern(cmd_type c);
      logic [39:0] p;
      unique case (c)
         CMD_SNG:  p = {"sng ", 8'h00};
         CMD_STS:  p = {"sts ", 8'h00};
         CMD_STP:  p = {"stp ", 8'h00};
         CMD_STMF: p = "stmf ";
         CMD_STMH: p = "stmh ";
         CMD_STDC: p = "stdc ";
         CMD_STDH: p = "stdh ";
         CMD_STD:  p = {"std ", 8'h00};
         CMD_ADC:  p = {"adc", 16'h0000};
         default:  p = '0;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] cmd_plen(cmd_type c);
      logic [2:0] n;
      unique case (c)
         CMD_STMF, CMD_STMH, CMD_STDC, CMD_STDH: n = 3'd5;
         CMD_ADC: n = 3'd3;
         default: n = 3'd4;
      endcase
      return n;
   endfunction

   // name sent back; adc is sent with a trailing space
   function automatic logic [IDX_W-1:0] name_len(cmd_type c);
      logic [IDX_W-1:0] n;
      unique case (c)
         CMD_STMF, CMD_STMH, CMD_STDC, CMD_STDH: n = IDX_W'(5);
         default: n = IDX_W'(4);
      endcase
      return n;
   endfunction

   function automatic logic [7:0] name_char(cmd_type c, logic [2:0] idx);
      logic [39:0] t;
      logic [7:0]  ch;
      t = (c == CMD_ADC) ? {"adc ", 8'h00} : cmd_pattern(c);
      unique case (idx)
         3'd0:    ch = t[39:32];
         3'd1:    ch = t[31:24];
         3'd2:    ch = t[23:16];
         3'd3:    ch = t[15:8];
         3'd4:    ch = t[7:0];
         default: ch = '0;
      endcase
      return ch;
   endfunction

   function automatic logic cmd_hit(cmd_type c, line_head_type h);
      logic [39:0] p;
      logic [2:0]  n;
      logic        ok;
      p  = cmd_pattern(c);
      n  = cmd_plen(c);
      ok = 1'b1;
      for (int k = 0; k < 5; k++) begin
         if (k < int'(n) && h[k] != p[39-8*k -: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [7:0] good_char(logic [IDX_W-1:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < GOOD_LEN) ch = GOOD_TEXT[8*(GOOD_LEN-1-int'(idx)) +: 8];
      return ch;
   endfunction

   function automatic logic [7:0] bad_char(logic [IDX_W-1:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < BAD_LEN) ch = BAD_TEXT[8*(BAD_LEN-1-int'(idx)) +: 8];
      return ch;
   endfunction

   function automatic logic [7:0] done_char(logic [IDX_W-1:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < DONE_LEN) ch = DONE_TEXT[8*(DONE_LEN-1-int'(idx)) +: 8];
      return ch;
   endfunction

endpackage

// ===== rtl/core/stepper_command_line_interpreter.sv =====
// top level of the stepper command line interpreter: sequencer plus datapath
// depends on scli_pkg, scli_ctrl and scli_datapath
//
// one received terminal byte comes in per req transaction and every character to
// transmit leaves as one rsp transaction; rsp_last marks the final character a byte
// causes, and a byte that sends nothing (escape outside adc mode, in adc mode anything
// but escape or a backspace with a character to erase) gives no rsp transaction at
// all. a byte is taken, the command match over the head of the line runs in the next
// cycle, then the sequencer sends one character per cycle while rsp_stall is low; a
// byte causes from 0 to 29 characters (a carriage return that hits a command with
// the accepted message is the longest case). req_stall stays high from the match
// until the last character has gone: one byte is handled at a time. motor and mode
// outputs show the state after the byte has been applied in full; the step and
// disable pulses appear on the last character and stay up until the match of the
// next byte clears them. LINE_LENGTH is the line length at which the write position
// wraps to zero; only the first six characters of a line are kept since nothing
// beyond the longest command name and its motor digit is ever matched.
module stepper_command_line_interpreter #(
   parameter int LINE_LENGTH = 20
) (
   input  logic       clock,
   input  logic       reset,
   // received byte channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // transmit character channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic       rsp_motor1_enable,
   output logic       rsp_motor2_enable,
   output logic       rsp_motor1_clockwise,
   output logic       rsp_motor2_clockwise,
   output logic       rsp_motor1_full_step,
   output logic       rsp_motor2_full_step,
   output logic [1:0] rsp_single_step_pulse,
   output logic [1:0] rsp_disable_pulse,
   output logic       rsp_adc_stream_on
);
   import scli_pkg::*;

   // commands from the sequencer, plan and match result back from the datapath
   ctrl_cmd_type ctrl_cmd;
   status_type   dp_status;

   scli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // line store, position and motor state live here
   scli_datapath #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (ctrl_cmd),
      .req_rx_byte           (req_rx_byte),
      .status                (dp_status),
      .rsp_tx_byte           (rsp_tx_byte),
      .rsp_last              (rsp_last),
      .rsp_motor1_enable     (rsp_motor1_enable),
      .rsp_motor2_enable     (rsp_motor2_enable),
      .rsp_motor1_clockwise  (rsp_motor1_clockwise),
      .rsp_motor2_clockwise  (rsp_motor2_clockwise),
      .rsp_motor1_full_step  (rsp_motor1_full_step),
      .rsp_motor2_full_step  (rsp_motor2_full_step),
      .rsp_single_step_pulse (rsp_single_step_pulse),
      .rsp_disable_pulse     (rsp_disable_pulse),
      .rsp_adc_stream_on     (rsp_adc_stream_on)
   );

endmodule

// ===== rtl/core/scli_ctrl.sv =====
// sequencer of the command line interpreter: takes a byte, runs the match, steps the text out
// depends on scli_pkg
module scli_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  scli_pkg::status_type   status,
   output scli_pkg::ctrl_cmd_type cmd
);
   import scli_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   state_type        after_echo, after;
   logic [IDX_W-1:0] seg_len;
   logic             seg_end;
   logic             take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      priority if (status.plan.erase)   after_echo = ST_ERASE_SP;
      else if (status.plan.finish)      after_echo = ST_FINISH;
      else if (status.plan.cmdline)     after_echo = ST_LINE_FEED;
      else                              after_echo = ST_IDLE;

      unique case (state_ff)
         ST_ECHO:      after = after_echo;
         ST_ERASE_SP:  after = ST_ERASE_BS;
         ST_LINE_FEED: after = status.hit ? ST_NAME : ST_REPLY;
         ST_NAME:      after = ST_REPLY;
         default:      after = ST_IDLE;
      endcase

      unique case (state_ff)
         ST_NAME:   seg_len = name_len(status.cmd);
         ST_REPLY:  seg_len = status.good ? IDX_W'(GOOD_LEN) : IDX_W'(BAD_LEN);
         ST_FINISH: seg_len = IDX_W'(DONE_LEN);
         default:   seg_len = IDX_W'(1);
      endcase
      seg_end = (idx_ff == seg_len - IDX_W'(1));

      rsp_valid = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      cmd.idx   = idx_ff;
      cmd.last  = seg_end && (after == ST_IDLE);
      unique case (state_ff)
         ST_ERASE_SP:  cmd.seg = SEG_SPACE;
         ST_ERASE_BS:  cmd.seg = SEG_BACK;
         ST_LINE_FEED: cmd.seg = SEG_LF;
         ST_NAME:      cmd.seg = SEG_NAME;
         ST_REPLY:     cmd.seg = SEG_REPLY;
         ST_FINISH:    cmd.seg = SEG_FINISH;
         default:      cmd.seg = SEG_ECHO;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            idx_in   = '0;
            state_in = status.plan.echo ? ST_ECHO : after_echo;
         end
         default: begin
            rsp_valid = 1'b1;
         end
      endcase

      take = rsp_valid && !rsp_stall;
      if (take) begin
         if (seg_end) begin
            state_in = after;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

endmodule

// ===== rtl/core/scli_datapath.sv =====
// line head store, position, mode flag, motor settings, command match and transmit text select
// depends on scli_pkg
module scli_datapath #(
   parameter int LINE_LENGTH = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scli_pkg::ctrl_cmd_type cmd,
   input  logic [7:0]             req_rx_byte,
   output scli_pkg::status_type   status,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last,
   output logic                   rsp_motor1_enable,
   output logic                   rsp_motor2_enable,
   output logic                   rsp_motor1_clockwise,
   output logic                   rsp_motor2_clockwise,
   output logic                   rsp_motor1_full_step,
   output logic                   rsp_motor2_full_step,
   output logic [1:0]             rsp_single_step_pulse,
   output logic [1:0]             rsp_disable_pulse,
   output logic                   rsp_adc_stream_on
);
   import scli_pkg::*;

   localparam int PW = $clog2(LINE_LENGTH);
   localparam logic [PW-1:0] LAST_POS = PW'(LINE_LENGTH - 1);

   line_head_type store_ff, store_in;
   logic [7:0]    byte_ff, byte_in;
   logic [PW-1:0] pos_ff, pos_in;
   plan_type      plan_ff, plan_in;
   logic          adc_ff, adc_in;
   logic [1:0]    en_ff, en_in, cw_ff, cw_in, full_ff, full_in;
   logic [1:0]    step_ff, step_in, dis_ff, dis_in;
   logic          hit_ff, hit_in, good_ff, good_in;
   cmd_type       cmd_ff, cmd_in;

   logic          match;
   cmd_type       match_cmd;
   logic [7:0]    arg;
   logic          arg_ok;
   logic [1:0]    sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         adc_ff  <= 1'b0;
         en_ff   <= '0;
         cw_ff   <= '0;
         full_ff <= '0;
         step_ff <= '0;
         dis_ff  <= '0;
         plan_ff <= '0;
         hit_ff  <= 1'b0;
         good_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         adc_ff  <= adc_in;
         en_ff   <= en_in;
         cw_ff   <= cw_in;
         full_ff <= full_in;
         step_ff <= step_in;
         dis_ff  <= dis_in;
         plan_ff <= plan_in;
         hit_ff  <= hit_in;
         good_ff <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      byte_ff  <= byte_in;
      cmd_ff   <= cmd_in;
   end

   // first table entry that matches the line head wins
   always_comb begin
      match     = 1'b0;
      match_cmd = CMD_SNG;
      for (int i = NUM_CMDS - 1; i >= 0; i--) begin
         if (cmd_hit(cmd_type'(4'(i)), store_ff)) begin
            match     = 1'b1;
            match_cmd = cmd_type'(4'(i));
         end
      end
      arg    = store_ff[cmd_plen(match_cmd)];
      arg_ok = (arg == CH_ONE) || (arg == CH_TWO);
      sel    = (arg == CH_TWO) ? 2'b10 : 2'b01;
   end

   always_comb begin
      store_in = store_ff;
      byte_in  = byte_ff;
      pos_in   = pos_ff;
      plan_in  = plan_ff;
      adc_in   = adc_ff;
      en_in    = en_ff;
      cw_in    = cw_ff;
      full_in  = full_ff;
      step_in  = step_ff;
      dis_in   = dis_ff;
      hit_in   = hit_ff;
      good_in  = good_ff;
      cmd_in   = cmd_ff;

      if (cmd.load) begin
         byte_in = req_rx_byte;
         if (pos_ff < PW'(STORE_DEPTH)) store_in[pos_ff[STORE_AW-1:0]] = req_rx_byte;
         plan_in.echo    = (req_rx_byte != CH_ESC) && !adc_ff;
         plan_in.erase   = (req_rx_byte == CH_BS) && (pos_ff != '0);
         plan_in.finish  = (req_rx_byte == CH_ESC) && adc_ff;
         plan_in.cmdline = (req_rx_byte == CH_CR) && !adc_ff;
         priority if (req_rx_byte == CH_BS) begin
            pos_in = (pos_ff != '0) ? pos_ff - PW'(1) : '0;
         end else if (plan_in.finish || plan_in.cmdline) begin
            pos_in = '0;
         end else begin
            pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + PW'(1);
         end
         if (plan_in.finish) adc_in = 1'b0;
      end

      if (cmd.exec) begin
         step_in = '0;
         dis_in  = '0;
         hit_in  = plan_ff.cmdline && match;
         cmd_in  = match_cmd;
         good_in = 1'b0;
         if (plan_ff.cmdline && match) begin
            if (match_cmd == CMD_ADC) begin
               adc_in  = 1'b1;
               good_in = 1'b1;
            end else if (arg_ok) begin
               good_in = 1'b1;
               unique case (match_cmd)
                  CMD_SNG: begin
                     en_in   = en_ff & ~sel;
                     step_in = sel;
                  end
                  CMD_STS:  en_in   = en_ff | sel;
                  CMD_STP:  en_in   = en_ff & ~sel;
                  CMD_STMF: full_in = full_ff | sel;
                  CMD_STMH: full_in = full_ff & ~sel;
                  CMD_STDC: cw_in   = cw_ff | sel;
                  CMD_STDH: cw_in   = cw_ff & ~sel;
                  default: begin
                     en_in  = en_ff & ~sel;
                     dis_in = sel;
                  end
               endcase
            end
         end
      end
   end

   assign status.plan = plan_ff;
   assign status.hit  = hit_ff;
   assign status.good = good_ff;
   assign status.cmd  = cmd_ff;

   always_comb begin
      unique case (cmd.seg)
         SEG_ECHO:   rsp_tx_byte = byte_ff;
         SEG_SPACE:  rsp_tx_byte = CH_SPACE;
         SEG_BACK:   rsp_tx_byte = CH_BS;
         SEG_LF:     rsp_tx_byte = CH_LF;
         SEG_NAME:   rsp_tx_byte = name_char(cmd_ff, cmd.idx[2:0]);
         SEG_REPLY:  rsp_tx_byte = good_ff ? good_char(cmd.idx) : bad_char(cmd.idx);
         SEG_FINISH: rsp_tx_byte = done_char(cmd.idx);
         default:    rsp_tx_byte = byte_ff;
      endcase
   end

   assign rsp_last              = cmd.last;
   assign rsp_motor1_enable     = en_ff[0];
   assign rsp_motor2_enable     = en_ff[1];
   assign rsp_motor1_clockwise  = cw_ff[0];
   assign rsp_motor2_clockwise  = cw_ff[1];
   assign rsp_motor1_full_step  = full_ff[0];
   assign rsp_motor2_full_step  = full_ff[1];
   assign rsp_single_step_pulse = cmd.last ? step_ff : 2'b00;
   assign rsp_disable_pulse     = cmd.last ? dis_ff : 2'b00;
   assign rsp_adc_stream_on     = adc_ff;

endmodule
